@@ hdl/pidaw_pkg.sv @@
// Shared types and constants for the PID controller with ramp and anti-windup.
package pidaw_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int ALPHA_Q15_DEF = 3277;

  // serial multiplier: A operand up to 32 bits, B operand 18 bits
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // serial divider for back-calculation
  localparam int DIV_N_W = 24;
  localparam int DIV_D_W = 16;

  localparam int CFG_AW = 5;

  typedef enum logic [2:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_INT_LIMIT = 3'd3,
    REG_OUT_MIN   = 3'd4,
    REG_OUT_MAX   = 3'd5,
    REG_RAMP_STEP = 3'd6,
    REG_DEADZONE  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic        [14:0] integral_limit;
    logic signed [15:0] output_min;
    logic signed [15:0] output_max;
    logic        [15:0] ramp_step;
    logic        [14:0] deadzone;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAMP,
    ST_ERR,
    ST_LP,
    ST_MUL_P,
    ST_MUL_I,
    ST_CLAMP,
    ST_DIV,
    ST_MUL_E,
    ST_LD,
    ST_MUL_D,
    ST_SUM,
    ST_FIN,
    ST_OUT
  } state_e;

endpackage

@@ hdl/pidaw_mul.sv @@
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
module pidaw_mul #(
  parameter int A_W = pidaw_pkg::MUL_A_W,
  parameter int B_W = pidaw_pkg::MUL_B_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [A_W-1:0]       a_i,
  input  logic [B_W-1:0]       b_i,
  output logic                 done_o,
  output logic [A_W+B_W-1:0]   prod_o
);
  import pidaw_pkg::*;

  localparam int CW = $clog2(B_W);

  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [A_W:0]  hi_q;
  logic [B_W-1:0] lo_q;
  logic [A_W-1:0] a_q;
  logic [A_W:0]  addend, sum;
  logic          last;

  assign last   = (cnt_q == CW'(B_W - 1));
  assign addend = lo_q[0] ? {a_q[A_W-1], a_q} : '0;
  // top bit of a two's complement multiplier carries negative weight
  assign sum    = last ? (hi_q - addend) : (hi_q + addend);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= {sum[A_W], sum[A_W:1]};
      lo_q <= {sum[0], lo_q[B_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q[A_W-1:0], lo_q};

endmodule

@@ hdl/pidaw_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module pidaw_div #(
  parameter int N_W = pidaw_pkg::DIV_N_W,
  parameter int D_W = pidaw_pkg::DIV_D_W
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic           done_o,
  output logic [N_W-1:0] quot_o
);
  import pidaw_pkg::*;

  localparam int CW = $clog2(N_W);

  logic [CW-1:0]  cnt_q;
  logic           busy_q, done_q;
  logic [D_W-1:0] rem_q, dv_q;
  logic [N_W-1:0] quo_q;
  logic [D_W:0]   r2, diff;
  logic           ge;

  assign r2   = {rem_q, quo_q[N_W-1]};
  assign ge   = (r2 >= {1'b0, dv_q});
  assign diff = r2 - {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dv_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[D_W-1:0] : r2[D_W-1:0];
      quo_q <= {quo_q[N_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ hdl/pidaw_cfg.sv @@
// APB register bank holding gains, limits, ramp step and deadzone.
module pidaw_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pidaw_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output pidaw_pkg::cfg_t               cfg_o
);
  import pidaw_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr;

  assign idx = reg_idx_e'(paddr[CFG_AW-1:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p         <= '0;
      cfg_q.gain_i         <= '0;
      cfg_q.gain_d         <= '0;
      cfg_q.integral_limit <= 15'd100;
      cfg_q.output_min     <= -16'sd100;
      cfg_q.output_max     <= 16'sd100;
      cfg_q.ramp_step      <= 16'd5;
      cfg_q.deadzone       <= 15'd5;
    end else if (wr) begin
      unique case (idx)
        REG_GAIN_P:    cfg_q.gain_p         <= pwdata[15:0];
        REG_GAIN_I:    cfg_q.gain_i         <= pwdata[15:0];
        REG_GAIN_D:    cfg_q.gain_d         <= pwdata[15:0];
        REG_INT_LIMIT: cfg_q.integral_limit <= pwdata[14:0];
        REG_OUT_MIN:   cfg_q.output_min     <= pwdata[15:0];
        REG_OUT_MAX:   cfg_q.output_max     <= pwdata[15:0];
        REG_RAMP_STEP: cfg_q.ramp_step      <= pwdata[15:0];
        REG_DEADZONE:  cfg_q.deadzone       <= pwdata[14:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_P:    prdata = {16'b0, cfg_q.gain_p};
      REG_GAIN_I:    prdata = {16'b0, cfg_q.gain_i};
      REG_GAIN_D:    prdata = {16'b0, cfg_q.gain_d};
      REG_INT_LIMIT: prdata = {17'b0, cfg_q.integral_limit};
      REG_OUT_MIN:   prdata = {16'b0, cfg_q.output_min};
      REG_OUT_MAX:   prdata = {16'b0, cfg_q.output_max};
      REG_RAMP_STEP: prdata = {16'b0, cfg_q.ramp_step};
      REG_DEADZONE:  prdata = {17'b0, cfg_q.deadzone};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/pid_with_ramp_and_antiwindup_unit.sv @@
// PID controller with setpoint ramp, deadzone, integral anti-windup and filtered derivative.
//
// Input stream: one transfer per control tick carrying target and measured samples.
// Output stream: one transfer per tick with the drive value and two status flags.
// Gains, limits, ramp step and deadzone are set over the APB port, and the user must
// write them only while idle (the block itself does not enforce this); pready is tied
// high and reads return the register contents. An input runs through ramp, error and
// accumulate steps, then four passes of one bit-serial 18-bit multiplier (P, I,
// derivative filter, D), a sum and the output clamp; when the integral clamps with a
// nonzero gain, a serial divide runs between the I and filter passes. A target inside
// the deadzone goes from the ramp step straight to the output. The next input is
// accepted only after the result reaches the output register, so no new sample is
// taken before the last one is done. A stalled receiver costs nothing until a second
// result is ready, after which the block holds in its final state.
// Reset clears the controller state (ramped setpoint, accumulator, previous
// sample, filtered rate) and loads the register defaults.
module pid_with_ramp_and_antiwindup_unit #(
  parameter int ALPHA_Q15 = pidaw_pkg::ALPHA_Q15_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [31:0]                   s_axis_tdata_i,  // [15:0] target, [31:16] measured
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [15:0]                   m_axis_tdata_o,  // [15:0] drive
  output logic [1:0]                    m_axis_tuser_o,  // [0] in_deadzone, [1] integral_clamped
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [pidaw_pkg::CFG_AW-1:0]  paddr_i,
  input  logic [31:0]                   pwdata_i,
  output logic [31:0]                   prdata_o,
  output logic                          pready_o
);
  import pidaw_pkg::*;

  localparam int SW = SAMPLE_W;

  cfg_t   cfg;
  state_e state_q, state_d;

  logic signed [SW-1:0] t_q, m_q, r_q, prev_q;
  logic signed [31:0]   acc_q;
  logic signed [SW:0]   rate_q, err_q;
  logic signed [SW+1:0] ediff_q;
  logic signed [32:0]   p_q;
  logic signed [23:0]   it_q;
  logic                 clamped_q, neg_q;
  logic signed [35:0]   s_q;
  logic signed [15:0]   res_drv_q;
  logic                 res_dz_q, res_cl_q;
  logic                 out_valid_q;
  logic signed [15:0]   out_drv_q;
  logic [1:0]           out_user_q;

  // multiplier and divider
  logic                  mul_start, mul_done, div_start, div_done;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic signed [MUL_P_W-1:0] mul_prod;
  logic [MUL_P_W-1:0]    mul_prod_u;
  logic [DIV_N_W-1:0]    div_n, quot;
  logic [DIV_D_W-1:0]    div_d;

  assign mul_prod = $signed(mul_prod_u);

  pidaw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel_i),
    .penable (penable_i),
    .pwrite  (pwrite_i),
    .paddr   (paddr_i),
    .pwdata  (pwdata_i),
    .prdata  (prdata_o),
    .cfg_o   (cfg)
  );
  assign pready_o = 1'b1;

  pidaw_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod_u)
  );

  pidaw_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // ---- combinational datapath pieces ----
  logic signed [SW:0]   t_x, dz_x;
  logic                 in_dz;
  logic signed [SW+1:0] dlt, step_x, dlt_c, r_sum;
  logic signed [32:0]   acc_sum;
  logic signed [31:0]   acc_sat;
  logic signed [MUL_P_W-1:0] lim_x;
  logic                 it_hi, it_lo, go_div;
  logic signed [23:0]   it_c;
  logic signed [MUL_P_W-1:0] ema_sum;
  logic signed [27:0]   drv_f, drv_c1, drv_c2;
  logic signed [15:0]   drv_fin;
  logic                 out_free;

  assign t_x   = SW'(0) + {t_q[SW-1], t_q};
  assign dz_x  = {2'b00, cfg.deadzone};
  assign in_dz = (t_x > -dz_x) && (t_x < dz_x);

  assign dlt    = {{2{t_q[SW-1]}}, t_q} - {{2{r_q[SW-1]}}, r_q};
  assign step_x = {2'b00, cfg.ramp_step};
  always_comb begin
    priority if (dlt > step_x)  dlt_c = step_x;
    else if (dlt < -step_x)     dlt_c = -step_x;
    else                        dlt_c = dlt;
  end
  assign r_sum = {{2{r_q[SW-1]}}, r_q} + dlt_c;

  assign acc_sum = {acc_q[31], acc_q} + {{16{err_q[SW]}}, err_q};
  always_comb begin
    if (acc_sum[32] != acc_sum[31])
      acc_sat = acc_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else
      acc_sat = acc_sum[31:0];
  end

  assign lim_x  = {{(MUL_P_W-23){1'b0}}, cfg.integral_limit, 8'b0};
  assign it_hi  = mul_prod > lim_x;
  assign it_lo  = mul_prod < -lim_x;
  always_comb begin
    priority if (it_hi) it_c = lim_x[23:0];
    else if (it_lo)     it_c = 24'(-lim_x);
    else                it_c = mul_prod[23:0];
  end
  assign go_div = (it_hi || it_lo) && (cfg.gain_i != 16'sd0);
  assign div_n  = it_c[23] ? 24'(-it_c) : it_c;
  assign div_d  = cfg.gain_i[15] ? 16'(-cfg.gain_i) : cfg.gain_i;

  // alpha*raw + (1-alpha)*old == alpha*(raw-old) + old, rounded
  assign ema_sum = mul_prod + ({{(MUL_P_W-SW-1){rate_q[SW]}}, rate_q} <<< 15)
                 + MUL_P_W'(16384);

  assign drv_f = s_q[35:8];
  assign drv_c1 = (drv_f > 28'(cfg.output_max)) ? 28'(cfg.output_max) : drv_f;
  assign drv_c2 = (drv_c1 < 28'(cfg.output_min)) ? 28'(cfg.output_min) : drv_c1;
  always_comb begin
    priority if (t_q > 0 && drv_c2 < 0) drv_fin = '0;
    else if (t_q < 0 && drv_c2 > 0)     drv_fin = '0;
    else if (t_q == 0)                  drv_fin = '0;
    else                                drv_fin = drv_c2[15:0];
  end

  assign out_free = !out_valid_q || m_axis_tready_i;

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_axis_tvalid_i) state_d = ST_RAMP;
      ST_RAMP:  state_d = in_dz ? ST_OUT : ST_ERR;
      ST_ERR:   state_d = ST_LP;
      ST_LP:    state_d = ST_MUL_P;
      ST_MUL_P: if (mul_done) state_d = ST_MUL_I;
      ST_MUL_I: if (mul_done) state_d = ST_CLAMP;
      ST_CLAMP: state_d = go_div ? ST_DIV : ST_MUL_E;
      ST_DIV:   if (div_done) state_d = ST_MUL_E;
      ST_MUL_E: if (mul_done) state_d = ST_LD;
      ST_LD:    state_d = ST_MUL_D;
      ST_MUL_D: if (mul_done) state_d = ST_SUM;
      ST_SUM:   state_d = ST_FIN;
      ST_FIN:   state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // ---- control outputs ----
  always_comb begin
    mul_start       = 1'b0;
    div_start       = 1'b0;
    mul_a           = {{(MUL_A_W-SW-2){ediff_q[SW+1]}}, ediff_q};
    mul_b           = MUL_B_W'(ALPHA_Q15);
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_LP: begin
        mul_start = 1'b1;
        mul_a     = {{(MUL_A_W-SW-1){err_q[SW]}}, err_q};
        mul_b     = {{2{cfg.gain_p[15]}}, cfg.gain_p};
      end
      ST_MUL_P: begin
        mul_start = mul_done;
        mul_a     = acc_q;
        mul_b     = {{2{cfg.gain_i[15]}}, cfg.gain_i};
      end
      ST_CLAMP: begin
        div_start = go_div;
        mul_start = !go_div;
      end
      ST_DIV:  mul_start = div_done;
      ST_LD: begin
        mul_start = 1'b1;
        mul_a     = {{(MUL_A_W-SW-1){rate_q[SW]}}, rate_q};
        mul_b     = {{2{cfg.gain_d[15]}}, cfg.gain_d};
      end
      default: ;
    endcase
  end

  // ---- registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      r_q         <= '0;
      acc_q       <= '0;
      prev_q      <= '0;
      rate_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready_i)          out_valid_q <= 1'b0;
      unique case (state_q)
        ST_RAMP: begin
          if (in_dz) begin
            r_q    <= '0;
            acc_q  <= '0;
            prev_q <= '0;
            rate_q <= '0;
          end else begin
            r_q <= r_sum[SW-1:0];
          end
        end
        ST_ERR:  prev_q <= m_q;
        // error is registered by now
        ST_LP:   acc_q <= acc_sat;
        ST_CLAMP: if (go_div) ;
        ST_DIV:  if (div_done) acc_q <= neg_q ? 32'(-{8'b0, quot}) : {8'b0, quot};
        ST_MUL_E: if (mul_done) rate_q <= ema_sum[SW+15:15];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        t_q <= s_axis_tdata_i[15:0];
        m_q <= s_axis_tdata_i[31:16];
      end
      ST_RAMP: begin
        res_drv_q <= '0;
        res_dz_q  <= in_dz;
        res_cl_q  <= 1'b0;
      end
      ST_ERR: begin
        err_q   <= {r_q[SW-1], r_q} - {m_q[SW-1], m_q};
        ediff_q <= ({{2{prev_q[SW-1]}}, prev_q} - {{2{m_q[SW-1]}}, m_q})
                 - {rate_q[SW], rate_q};
      end
      ST_MUL_P: if (mul_done) p_q <= mul_prod[32:0];
      ST_CLAMP: begin
        it_q      <= it_c;
        clamped_q <= it_hi || it_lo;
        neg_q     <= it_c[23] ^ cfg.gain_i[15];
      end
      ST_SUM: s_q <= {{3{p_q[32]}}, p_q} + {{12{it_q[23]}}, it_q}
                   + {{3{mul_prod[32]}}, mul_prod[32:0]} + 36'sd128;
      ST_FIN: begin
        res_drv_q <= drv_fin;
        res_cl_q  <= clamped_q;
      end
      ST_OUT: if (out_free) begin
        out_drv_q  <= res_drv_q;
        out_user_q <= {res_cl_q, res_dz_q};
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_drv_q;
  assign m_axis_tuser_o  = out_user_q;

  // ---- assertions ----
  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_MUL_P || state_q == ST_MUL_I ||
                  state_q == ST_MUL_E || state_q == ST_MUL_D))
    else $error("multiplier finished outside a multiply state");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |->
      (m_axis_tdata_o == 16'd0 && !m_axis_tuser_o[1]))
    else $error("deadzone result with nonzero drive or clamp flag");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> state_q == ST_RAMP)
    else $error("accepted item did not start processing");

endmodule

@@ tb/sv/tb_pid_with_ramp_and_antiwindup_unit.sv @@
// Self-checking testbench for the PID controller with ramp, deadzone and anti-windup.
module tb_pid_with_ramp_and_antiwindup_unit;
  import pidaw_pkg::*;

  typedef struct {
    logic signed [15:0] target;
    logic signed [15:0] measured;
  } sample_t;

  typedef struct {
    logic [15:0] drive;
    logic        in_dz;
    logic        int_clamp;
  } ctrl_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        psel_i = 1'b0;
  logic        penable_i = 1'b0;
  logic        pwrite_i = 1'b0;
  logic [CFG_AW-1:0] paddr_i = '0;
  logic [31:0] pwdata_i = '0;
  logic [31:0] prdata_o;
  logic        pready_o;

  pid_with_ramp_and_antiwindup_unit u_dut (.*);

  initial forever #10 clk_i = ~clk_i;

  // controller copy: registers and loop state
  longint kp, ki, kd, i_lim, out_lo, out_hi, slope;
  int     dz_band;
  longint sp_ramp, acc, prev_meas, rate_f;

  sample_t   pending_q[$];
  ctrl_out_t expected_q[$];
  int        n_errors = 0;
  bit        no_idle = 0;

  function automatic ctrl_out_t predict_tick(sample_t s);
    ctrl_out_t r;
    longint t, m, step, err, p, it, lim, raw, d, drv;
    t = s.target;
    m = s.measured;
    r.in_dz = 1'b0;
    r.int_clamp = 1'b0;
    if (t > -dz_band && t < dz_band) begin
      sp_ramp = 0; acc = 0; prev_meas = 0; rate_f = 0;
      r.drive = '0;
      r.in_dz = 1'b1;
      return r;
    end
    step = t - sp_ramp;
    if (step > slope) step = slope;
    else if (step < -slope) step = -slope;
    sp_ramp += step;
    err = sp_ramp - m;
    p = kp * err;
    acc += err;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    it = ki * acc;
    lim = i_lim * 256;
    if (it > lim) begin
      it = lim; r.int_clamp = 1'b1;
    end
    if (it < -lim) begin
      it = -lim; r.int_clamp = 1'b1;
    end
    if (r.int_clamp && ki != 0) acc = it / ki;
    raw = prev_meas - m;
    prev_meas = m;
    rate_f = (longint'(ALPHA_Q15_DEF) * raw + longint'(32768 - ALPHA_Q15_DEF) * rate_f
              + 16384) >>> 15;
    d = kd * rate_f;
    drv = (p + it + d + 128) >>> 8;
    if (drv > out_hi) drv = out_hi;
    if (drv < out_lo) drv = out_lo;
    if ((t > 0 && drv < 0) || (t < 0 && drv > 0) || t == 0) drv = 0;
    r.drive = drv[15:0];
    return r;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    psel_i <= 1'b1; penable_i <= 1'b0; pwrite_i <= 1'b1;
    paddr_i <= CFG_AW'({idx, 2'b00}); pwdata_i <= {16'h0, val};
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    psel_i <= 1'b0; penable_i <= 1'b0; pwrite_i <= 1'b0;
    case (idx)
      REG_GAIN_P:    kp = longint'($signed(val));
      REG_GAIN_I:    ki = longint'($signed(val));
      REG_GAIN_D:    kd = longint'($signed(val));
      REG_INT_LIMIT: i_lim = longint'(val[14:0]);
      REG_OUT_MIN:   out_lo = longint'($signed(val));
      REG_OUT_MAX:   out_hi = longint'($signed(val));
      REG_RAMP_STEP: slope = longint'(val);
      REG_DEADZONE:  dz_band = int'(val[14:0]);
      default: ;
    endcase
  endtask

  task automatic set_all(logic [15:0] p, logic [15:0] i, logic [15:0] d, logic [15:0] lim,
                         logic [15:0] lo, logic [15:0] hi, logic [15:0] rs, logic [15:0] dz);
    write_reg(REG_GAIN_P, p);    write_reg(REG_GAIN_I, i);
    write_reg(REG_GAIN_D, d);    write_reg(REG_INT_LIMIT, lim);
    write_reg(REG_OUT_MIN, lo);  write_reg(REG_OUT_MAX, hi);
    write_reg(REG_RAMP_STEP, rs); write_reg(REG_DEADZONE, dz);
  endtask

  function automatic void push(int t, int m);
    sample_t s;
    s.target = t[15:0];
    s.measured = m[15:0];
    pending_q.push_back(s);
  endfunction

  // drain both queues, then allow the block to settle before touching registers
  task automatic drain();
    while (pending_q.size() != 0 || expected_q.size() != 0 || s_axis_tvalid_i)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // runs of a steady target with feedback near it, plus noise and deadzone hits
  task automatic random_phase(int n);
    int t, m, run;
    while (n > 0) begin
      case ($urandom_range(0, 9))
        0: begin
          push($urandom(), $urandom()); n--;
        end
        1: begin
          push($signed($urandom_range(0, 2 * dz_band + 2)) - dz_band - 1,
               $urandom_range(0, 200) - 100);
          n--;
        end
        default: begin
          t = (dz_band + $urandom_range(0, 3000));
          if ($urandom_range(0, 9) == 0) t = $urandom_range(dz_band, 32767);
          if ($urandom_range(0, 1)) t = -t;
          if (t > 32767) t = 32767;
          if (t < -32768) t = -32768;
          run = $urandom_range(3, 20);
          m = t / 2;
          repeat (run) begin
            m = m + ($signed($urandom_range(0, 400)) - 200) + (t - m) / 4;
            if (m > 32767) m = 32767;
            if (m < -32768) m = -32768;
            push(t, m);
            n--;
          end
        end
      endcase
    end
  endtask

  // sender
  int s_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_q.push_back(predict_tick(pending_q.pop_front()));
        s_gap = no_idle ? 0 : $urandom_range(0, 8);
        if (s_gap == 0 && pending_q.size() != 0)
          s_axis_tdata_i <= {pending_q[0].measured, pending_q[0].target};
        else
          s_axis_tvalid_i <= 1'b0;
      end else if (!s_axis_tvalid_i) begin
        if (s_gap > 0) s_gap--;
        else if (pending_q.size() != 0) begin
          s_axis_tdata_i <= {pending_q[0].measured, pending_q[0].target};
          s_axis_tvalid_i <= 1'b1;
        end
      end
    end
  end

  // receiver and checker
  int m_stall = 0;
  always @(posedge clk_i) begin
    ctrl_out_t e;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transfer drive %h tuser %b", $time,
                   m_axis_tdata_o, m_axis_tuser_o);
          n_errors++;
        end else begin
          e = expected_q.pop_front();
          if (m_axis_tdata_o !== e.drive) begin
            $display("%0t: drive expected %0d actual %0d", $time, $signed(e.drive),
                     $signed(m_axis_tdata_o));
            n_errors++;
          end
          if (m_axis_tuser_o[0] !== e.in_dz) begin
            $display("%0t: in_deadzone expected %b actual %b", $time, e.in_dz,
                     m_axis_tuser_o[0]);
            n_errors++;
          end
          if (m_axis_tuser_o[1] !== e.int_clamp) begin
            $display("%0t: integral_clamped expected %b actual %b", $time, e.int_clamp,
                     m_axis_tuser_o[1]);
            n_errors++;
          end
        end
        m_stall = no_idle ? 0 : $urandom_range(0, 8);
        if (m_stall > 0) m_axis_tready_i <= 1'b0;
      end else if (!m_axis_tready_i) begin
        if (m_stall > 0) m_stall--;
        else m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    int k;
    kp = 0; ki = 0; kd = 0; i_lim = 100; out_lo = -100; out_hi = 100;
    slope = 5; dz_band = 5;
    sp_ramp = 0; acc = 0; prev_meas = 0; rate_f = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: gains zero, deadzone edges
    push(4, 0); push(5, 0); push(-5, 3); push(-4, 0); push(300, 10);
    drain();

    set_all(16'd256, 16'd16, 16'd128, 16'd100, -16'sd100, 16'sd100, 16'd5, 16'd5);
    push(32767, -32768); push(32767, -32768); push(-32768, 32767); push(-32768, 32767);
    push(100, 0); push(100, 200); push(-100, -200); push(6, -6); push(-6, 6);
    drain();

    // zero integral gain and zero integral limit, inverted output limits, zero target
    set_all(16'd512, 16'd0, -16'sd300, 16'd0, 16'sd50, -16'sd50, 16'd65535, 16'd0);
    push(0, 0); push(0, 1000); push(1000, 0); push(-1000, 0); push(-2000, 4000);
    drain();

    // gain extremes, widest limits
    set_all(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'd0, 16'h7fff);
    push(32767, 32767); push(-32768, -32768); push(32766, 0); push(-32767, 100);
    no_idle = 1;
    drain();
    no_idle = 0;

    for (k = 0; k < 8; k++) begin
      if (k % 2)
        set_all(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
      else
        set_all(16'($urandom_range(0, 2048) - 1024), 16'($urandom_range(0, 256) - 128),
                16'($urandom_range(0, 4096) - 2048), 16'($urandom_range(0, 2000)),
                16'(-$urandom_range(0, 5000)), 16'($urandom_range(0, 5000)),
                16'($urandom_range(0, 300)), 16'($urandom_range(0, 50)));
      no_idle = (k == 3);
      random_phase(60);
      drain();
    end

    repeat (150) @(posedge clk_i);
    if (n_errors == 0)
      $display("tb_pid_with_ramp_and_antiwindup_unit: done, clean");
    else
      $display("tb_pid_with_ramp_and_antiwindup_unit: done, errors");
    $finish;
  end

  initial begin
    #40000000;
    $display("tb_pid_with_ramp_and_antiwindup_unit: done, errors");
    $finish;
  end

endmodule
